/* hdl/scfd_pkg.sv */
// Shared types, widths and lookup tables for the smartcard Fi/Di rate calculator.
// No dependencies; imported by every module of the block.
`default_nettype none

package scfd_pkg;

  localparam int unsigned FI_W     = 12;  // Fi factor, up to 2048
  localparam int unsigned DI_W     = 7;   // Di factor, up to 64
  localparam int unsigned CFG_W    = 8;   // configuration data width
  localparam int unsigned CFG_IDX_W = 2;  // configuration register index width
  localparam int unsigned CNT_W    = 17;  // timer count / reload / ticks
  localparam int unsigned PRE_W    = 3;   // prescale halvings
  localparam int unsigned RLD_W    = 16;  // reload word
  localparam int unsigned GUARD_W  = 25;  // guard ticks

  // Serial multiplier: 17-bit multiplicand times 8-bit multiplier
  localparam int unsigned MUL_A_W  = 17;
  localparam int unsigned MUL_B_W  = 8;
  localparam int unsigned MUL_P_W  = 25;

  // Serial divider: 19-bit dividend, 7-bit divisor
  localparam int unsigned DIV_N_W  = 19;
  localparam int unsigned DIV_D_W  = 7;

  // Rate numerator Fi*cd + 8*Di
  localparam int unsigned RNUM_W   = 21;

  localparam logic [CNT_W-1:0] COUNT_LIMIT = 17'd65536;
  localparam logic [PRE_W-1:0] PRE_MAX     = 3'd7;
  localparam logic [CFG_W-1:0] GUARD_NONE  = 8'hFF;
  localparam logic [FI_W-1:0]  FI_RESET    = 12'd372;
  localparam logic [DI_W-1:0]  DI_RESET    = 7'd1;
  localparam logic [CFG_W-1:0] CARD_DIV_RESET = 8'd2;
  localparam logic [DIV_D_W-1:0] TICK_DIVISOR = 7'd3;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_CARD_DIVIDER = 2'd0,
    CFG_GUARD_N      = 2'd1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_MUL_RATE,
    S_DIV_RATE,
    S_HALVE,
    S_DIV_TICK,
    S_MUL_GUARD,
    S_DONE
  } state_t;

  // ISO 7816-3 Fi table, zero marks a reserved code
  function automatic logic [FI_W-1:0] fi_lookup(input logic [3:0] code);
    logic [FI_W-1:0] f;
    case (code)
      4'h0:    f = 12'd372;
      4'h1:    f = 12'd372;
      4'h2:    f = 12'd558;
      4'h3:    f = 12'd744;
      4'h4:    f = 12'd1116;
      4'h5:    f = 12'd1488;
      4'h6:    f = 12'd1860;
      4'h9:    f = 12'd512;
      4'hA:    f = 12'd768;
      4'hB:    f = 12'd1024;
      4'hC:    f = 12'd1536;
      4'hD:    f = 12'd2048;
      default: f = '0;
    endcase
    return f;
  endfunction

  // ISO 7816-3 Di table, zero marks a reserved code
  function automatic logic [DI_W-1:0] di_lookup(input logic [3:0] code);
    logic [DI_W-1:0] d;
    case (code)
      4'h1:    d = 7'd1;
      4'h2:    d = 7'd2;
      4'h3:    d = 7'd4;
      4'h4:    d = 7'd8;
      4'h5:    d = 7'd16;
      4'h6:    d = 7'd32;
      4'h7:    d = 7'd64;
      4'h8:    d = 7'd12;
      4'h9:    d = 7'd20;
      default: d = '0;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

/* hdl/scfd_serial_mul.sv */
// Bit-serial shift-and-add multiplier, one multiplier bit per cycle.
// Depends on scfd_pkg for operand and product widths.
`default_nettype none

module scfd_serial_mul
  import scfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [MUL_A_W-1:0] a,
  input  logic [MUL_B_W-1:0] b,
  output logic               done,
  output logic [MUL_P_W-1:0] product
);

  localparam int unsigned STEP_W = $clog2(MUL_B_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [MUL_P_W-1:0] acc;
  logic [MUL_P_W-1:0] a_sh;
  logic [MUL_B_W-1:0] b_sh;
  logic [MUL_P_W-1:0] acc_next;

  assign acc_next = b_sh[0] ? MUL_P_W'(acc + a_sh) : acc;
  assign product  = acc;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= STEP_W'(step + 1'b1);
        if (step == STEP_W'(MUL_B_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      acc  <= '0;
      a_sh <= MUL_P_W'(a);
      b_sh <= b;
    end else if (busy) begin
      acc  <= acc_next;
      a_sh <= {a_sh[MUL_P_W-2:0], 1'b0};
      b_sh <= {1'b0, b_sh[MUL_B_W-1:1]};
    end
  end

endmodule

`default_nettype wire

/* hdl/scfd_serial_div.sv */
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on scfd_pkg for dividend and divisor widths.
`default_nettype none

module scfd_serial_div
  import scfd_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic [DIV_N_W-1:0] numer,
  input  logic [DIV_D_W-1:0] denom,
  output logic               done,
  output logic [DIV_N_W-1:0] quotient
);

  localparam int unsigned STEP_W = $clog2(DIV_N_W);

  logic               busy;
  logic [STEP_W-1:0]  step;
  logic [DIV_N_W-1:0] quo;     // dividend shifts out, quotient shifts in
  logic [DIV_D_W-1:0] rem;
  logic [DIV_D_W-1:0] den;
  logic [DIV_D_W:0]   trial;
  logic               fits;

  assign trial    = {rem, quo[DIV_N_W-1]};
  assign fits     = trial >= {1'b0, den};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        step <= '0;
      end else if (busy) begin
        step <= STEP_W'(step + 1'b1);
        if (step == STEP_W'(DIV_N_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo <= numer;
      rem <= '0;
      den <= denom;
    end else if (busy) begin
      // subtract when the trial remainder covers the divisor
      rem <= fits ? DIV_D_W'(trial - {1'b0, den}) : trial[DIV_D_W-1:0];
      quo <= {quo[DIV_N_W-2:0], fits};
    end
  end

endmodule

`default_nettype wire

/* hdl/smartcard_fi_di_rate_calculator.sv */
// Smartcard Fi/Di baud rate calculator, top level: sequencer, state and output word.
// Depends on scfd_pkg, scfd_serial_mul and scfd_serial_div.
//
// Usage:
//   Input channel (in_valid/in_ready, ta1_byte) takes one TA1 word per item. The
//   high nibble picks Fi, the low nibble Di. The pair is applied when both table
//   entries are defined and the rounded divisor (Fi*cd + 8Di)/(16Di) is at least 2;
//   otherwise the stored pair stays and supported reads 0.
//   Output channel (out_valid/out_ready) carries one result word per input word:
//   the pair in use, timer count, prescale, reload word, effective reload,
//   ticks per etu and guard ticks.
//   Configuration port (cfg_write_en/cfg_index/cfg_data) writes card_divider
//   (index 0) and guard_n (index 1); write only while idle.
// Sequence:
//   A serial multiply and a serial divide for the divisor, a second serial divide for
//   ticks per etu and a serial multiply for guard ticks run in turn; the guard multiply
//   is skipped when guard time is off, and when a defined pair fails the divisor check
//   the old pair is multiplied and divided again. One item is in work at a time.
// Reset and stalls:
//   rst clears the sequencer, restores Fi=372, Di=1, card_divider=2, guard_n=0.
//   The result word sits in an output register, so the next TA1 word is taken while
//   a result waits; a finished result then holds in the sequencer until the output
//   register frees up.
`default_nettype none

module smartcard_fi_di_rate_calculator
  import scfd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  // configuration
  input  logic                 cfg_write_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  // input channel
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           ta1_byte,
  // output channel
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic                 supported,
  output logic [FI_W-1:0]      fi_value,
  output logic [DI_W-1:0]      di_value,
  output logic [CNT_W-1:0]     timer_count,
  output logic [PRE_W-1:0]     prescale,
  output logic [RLD_W-1:0]     reload_word,
  output logic [CNT_W-1:0]     effective_reload,
  output logic [CNT_W-1:0]     ticks_per_etu,
  output logic [GUARD_W-1:0]   guard_ticks
);

  state_t state, state_next;

  // configuration registers
  logic [CFG_W-1:0] card_divider;
  logic [CFG_W-1:0] guard_n;

  // stored pair
  logic [FI_W-1:0] cur_fi;
  logic [DI_W-1:0] cur_di;

  // working registers
  logic             cand_pass;   // dividing the candidate pair, not the stored one
  logic             ok;
  logic [FI_W-1:0]  work_f;
  logic [DI_W-1:0]  work_d;
  logic [CNT_W-1:0] count;
  logic [PRE_W-1:0] pre;
  logic [CNT_W-1:0] ticks;
  logic [GUARD_W-1:0] guard;

  // arithmetic units
  logic               mul_start, mul_done;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;
  logic               div_start, div_done;
  logic [DIV_N_W-1:0] div_num;
  logic [DIV_D_W-1:0] div_den;
  logic [DIV_N_W-1:0] div_q;

  // decode of the incoming word
  logic [FI_W-1:0] cand_f;
  logic [DI_W-1:0] cand_d;
  logic            cand_valid;
  logic [FI_W-1:0] start_f;
  logic [DI_W-1:0] start_d;

  logic [RNUM_W-1:0] rate_num;
  logic [CNT_W-1:0]  eff;
  logic              halve_needed;
  logic              guard_on;
  logic              div_rejects;
  logic              out_free;

  assign cand_f     = fi_lookup(ta1_byte[7:4]);
  assign cand_d     = di_lookup(ta1_byte[3:0]);
  assign cand_valid = (cand_f != '0) && (cand_d != '0);
  assign start_f    = cand_valid ? cand_f : cur_fi;
  assign start_d    = cand_valid ? cand_d : cur_di;

  // Fi*cd + 8*Di, cd = 1 for code zero else twice the code
  assign rate_num = ((card_divider == '0) ? RNUM_W'(work_f)
                                          : RNUM_W'({mul_p[RNUM_W-2:0], 1'b0}))
                    + RNUM_W'({work_d, 3'b000});

  assign eff          = count << pre;
  assign halve_needed = (count > COUNT_LIMIT) && (pre != PRE_MAX);
  assign guard_on     = (guard_n != '0) && (guard_n != GUARD_NONE);
  assign div_rejects  = cand_pass && (div_q < DIV_N_W'(2));
  assign out_free     = !out_valid || out_ready;

  scfd_serial_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .product (mul_p)
  );

  scfd_serial_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .numer    (div_num),
    .denom    (div_den),
    .done     (div_done),
    .quotient (div_q)
  );

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:      if (in_valid) state_next = S_MUL_RATE;
      S_MUL_RATE:  if (mul_done) state_next = S_DIV_RATE;
      S_DIV_RATE: begin
        if (div_done) state_next = div_rejects ? S_MUL_RATE : S_HALVE;
      end
      S_HALVE:     if (!halve_needed) state_next = S_DIV_TICK;
      S_DIV_TICK: begin
        if (div_done) state_next = guard_on ? S_MUL_GUARD : S_DONE;
      end
      S_MUL_GUARD: if (mul_done) state_next = S_DONE;
      S_DONE:      if (out_free) state_next = S_IDLE;
      default:     state_next = S_IDLE;
    endcase
  end

  // unit launches and handshake
  always_comb begin
    in_ready  = 1'b0;
    mul_start = 1'b0;
    mul_a     = MUL_A_W'(start_f);
    mul_b     = card_divider;
    div_start = 1'b0;
    div_num   = DIV_N_W'(rate_num[RNUM_W-1:4]);
    div_den   = work_d;
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        mul_start = in_valid;
      end
      S_MUL_RATE: begin
        div_start = mul_done;
      end
      S_DIV_RATE: begin
        // rejected candidate: divide the stored pair instead
        mul_start = div_done && div_rejects;
        mul_a     = MUL_A_W'(cur_fi);
      end
      S_HALVE: begin
        div_start = !halve_needed;
        div_num   = DIV_N_W'({eff, 2'b10});
        div_den   = TICK_DIVISOR;
      end
      S_DIV_TICK: begin
        mul_start = div_done && guard_on;
        mul_a     = div_q[MUL_A_W-1:0];
        mul_b     = guard_n;
      end
      S_MUL_GUARD, S_DONE: begin
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      card_divider <= CARD_DIV_RESET;
      guard_n      <= '0;
      cur_fi       <= FI_RESET;
      cur_di       <= DI_RESET;
      cand_pass    <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_write_en) begin
        unique case (cfg_index)
          CFG_CARD_DIVIDER: card_divider <= cfg_data;
          CFG_GUARD_N:      guard_n      <= cfg_data;
          default: ;  // drop writes beyond the register list
        endcase
      end
      if (state == S_IDLE && in_valid) begin
        cand_pass <= cand_valid;
      end
      if (state == S_DIV_RATE && div_done && cand_pass) begin
        cand_pass <= 1'b0;
        if (!div_rejects) begin
          cur_fi <= work_f;
          cur_di <= work_d;
        end
      end
      if (state == S_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working values and output word
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          work_f <= start_f;
          work_d <= start_d;
          ok     <= 1'b0;
        end
      end
      S_DIV_RATE: begin
        if (div_done) begin
          if (div_rejects) begin
            work_f <= cur_fi;
            work_d <= cur_di;
          end else begin
            ok    <= cand_pass;
            count <= div_q[CNT_W-1:0];
            pre   <= '0;
          end
        end
      end
      S_HALVE: begin
        if (halve_needed) begin
          count <= CNT_W'(({1'b0, count} + (CNT_W+1)'(1)) >> 1);
          pre   <= PRE_W'(pre + 1'b1);
        end
      end
      S_DIV_TICK: begin
        if (div_done) begin
          ticks <= div_q[CNT_W-1:0];
          guard <= '0;
        end
      end
      S_MUL_GUARD: begin
        if (mul_done) guard <= mul_p;
      end
      S_DONE: begin
        if (out_free) begin
          supported        <= ok;
          fi_value         <= cur_fi;
          di_value         <= cur_di;
          timer_count      <= count;
          prescale         <= pre;
          reload_word      <= RLD_W'(RLD_W'(0) - count[RLD_W-1:0]);
          effective_reload <= eff;
          ticks_per_etu    <= ticks;
          guard_ticks      <= guard;
        end
      end
      default: begin
      end
    endcase
  end

  // an accepted word always starts the multiply for the divisor
  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> state == S_MUL_RATE)
    else $error("accepted word did not start the divisor multiply");

  // a new result word comes only out of the final sequencer step
  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state) == S_DONE)
    else $error("result word raised outside the final step");

  // an applied pair always yields a divisor of at least two
  a_supported_count: assert property (@(posedge clk) disable iff (rst)
    out_valid && supported |-> timer_count >= CNT_W'(2))
    else $error("applied pair with divisor below two");

  // the divider reports only while the sequencer waits on it
  a_div_expected: assert property (@(posedge clk) disable iff (rst)
    div_done |-> state == S_DIV_RATE || state == S_DIV_TICK)
    else $error("divider finished outside a divide step");

endmodule

`default_nettype wire
